/* rtl/core/acc_pkg.sv */
package acc_pkg;

  localparam int Q_W        = 15;
  localparam int FRAC_SHIFT = 28;
  localparam logic [Q_W-1:0] ONE_Q14 = 15'd16384;
  localparam logic [3:0] SQ_LAST = 4'd14;

  // product order of the final evaluation
  typedef enum logic [2:0] {
    SEL_N_SAB   = 3'd0,
    SEL_SA_SB   = 3'd1,
    SEL_N_SAA   = 3'd2,
    SEL_SA_SA   = 3'd3,
    SEL_N_SBB   = 3'd4,
    SEL_SB_SB   = 3'd5,
    SEL_VA_VB   = 3'd6,
    SEL_NUM_NUM = 3'd7
  } mul_sel_t;

  typedef struct packed {
    logic     acc_en;
    logic     clr;
    logic     mul_load;
    logic     mul_step;
    logic     mul_store;
    logic     sq_init;
    logic     sq_trial;
    logic     sq_update;
    logic     out_load;
    mul_sel_t sel;
  } acc_cmd_t;

endpackage

/* rtl/core/acc_if.sv */
interface acc_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [15:0]       lag_value_lower;
  logic signed [15:0]       lag_value_upper;
  logic                     last_lag;

  modport source (output valid, lag_value_lower, lag_value_upper, last_lag, input ready);
  modport sink   (input valid, lag_value_lower, lag_value_upper, last_lag, output ready);
endinterface

interface acc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] correlation;
  logic               overflow_flag;

  modport source (output valid, correlation, overflow_flag, input ready);
  modport sink   (input valid, correlation, overflow_flag, output ready);
endinterface

/* rtl/core/acc_ctrl.sv */
module acc_ctrl #(
  parameter int MAX_LAGS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output acc_pkg::acc_cmd_t cmd
);

  localparam int CW  = $clog2(MAX_LAGS + 1);
  localparam int MW  = 2 * CW + 30;
  localparam int CNW = $clog2(MW);

  typedef enum logic [7:0] {
    ST_ACC      = 8'b0000_0001,
    ST_MLOAD    = 8'b0000_0010,
    ST_MSTEP    = 8'b0000_0100,
    ST_MSTORE   = 8'b0000_1000,
    ST_SQ_INIT  = 8'b0001_0000,
    ST_SQ_TRIAL = 8'b0010_0000,
    ST_SQ_UPD   = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  acc_pkg::mul_sel_t   sel_r, sel_nxt;
  logic [CNW-1:0]      cnt_r, cnt_nxt;
  logic [3:0]          it_r, it_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                accept;

  assign in_ready  = (state_r == ST_ACC);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    cnt_nxt       = cnt_r;
    it_nxt        = it_r;
    cmd           = '0;
    cmd.sel       = sel_r;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    unique case (state_r)
      ST_ACC: begin
        cmd.acc_en = accept;
        if (accept && in_last) begin
          sel_nxt   = acc_pkg::SEL_N_SAB;
          state_nxt = ST_MLOAD;
        end
      end
      ST_MLOAD: begin
        cmd.mul_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_MSTEP;
      end
      ST_MSTEP: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNW'(MW - 1)) begin
          state_nxt = ST_MSTORE;
        end
      end
      ST_MSTORE: begin
        cmd.mul_store = 1'b1;
        if (sel_r == acc_pkg::SEL_NUM_NUM) begin
          state_nxt = ST_SQ_INIT;
        end else begin
          sel_nxt   = acc_pkg::mul_sel_t'(sel_r + 3'd1);
          state_nxt = ST_MLOAD;
        end
      end
      ST_SQ_INIT: begin
        cmd.sq_init = 1'b1;
        it_nxt      = '0;
        state_nxt   = ST_SQ_TRIAL;
      end
      ST_SQ_TRIAL: begin
        cmd.sq_trial = 1'b1;
        state_nxt    = ST_SQ_UPD;
      end
      ST_SQ_UPD: begin
        cmd.sq_update = 1'b1;
        it_nxt        = it_r + 4'd1;
        state_nxt     = (it_r == acc_pkg::SQ_LAST) ? ST_DONE : ST_SQ_TRIAL;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          cmd.clr       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      sel_r       <= acc_pkg::SEL_N_SAB;
      cnt_r       <= '0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      cnt_r       <= cnt_nxt;
      it_r        <= it_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/core/acc_dp.sv */
module acc_dp #(
  parameter int MAX_LAGS = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  acc_pkg::acc_cmd_t         cmd,
  input  logic signed [15:0]        lag_value_lower,
  input  logic signed [15:0]        lag_value_upper,
  output logic signed [15:0]        correlation,
  output logic                      overflow_flag
);

  localparam int CW = $clog2(MAX_LAGS + 1);
  localparam int SW = CW + 16;
  localparam int XW = CW + 31;
  localparam int QW = CW + 30;
  localparam int MW = 2 * CW + 30;
  localparam int VW = MW + 2;
  localparam int PW = 2 * MW + 1;
  localparam int RW = 2 * MW + acc_pkg::FRAC_SHIFT;
  localparam int TW = RW + 2;
  localparam int QB = acc_pkg::Q_W;

  // running sums
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic signed [SW-1:0] sa_r, sa_nxt, sb_r, sb_nxt;
  logic signed [XW-1:0] sab_r, sab_nxt;
  logic [QW-1:0]        saa_r, saa_nxt, sbb_r, sbb_nxt;
  logic                 ovf_r, ovf_nxt;
  logic signed [31:0]   prod_ab, prod_aa, prod_bb;

  // shift-add multiplier
  logic [MW-1:0]        ma_r, ma_nxt;
  logic [PW-1:0]        mp_r, mp_nxt;
  logic                 msign_r, msign_nxt;
  logic [MW:0]          madd;
  logic [MW-1:0]        op_a, op_b;
  logic                 op_sign;
  logic signed [VW-1:0] pm, spv;

  // evaluation terms
  logic signed [VW-1:0] t0_r, t0_nxt, num_r, num_nxt, va_r, va_nxt, vb_r, vb_nxt;
  logic [2*MW-1:0]      den_r, den_nxt, rhs_r, rhs_nxt;
  logic [SW-1:0]        sa_mag, sb_mag;
  logic [XW-1:0]        sab_mag;
  logic [VW-1:0]        num_mag;

  // square root search
  logic [TW-1:0]        d_r, d_nxt, e_r, e_nxt, q2d_r, q2d_nxt, trial_r, trial_nxt;
  logic [TW:0]          esum;
  logic [TW-1:0]        rhs_sh;
  logic                 fit;
  logic [QB-1:0]        q_r, q_nxt, q_clamp;
  logic [15:0]          mag16;

  logic signed [15:0]   corr_r, corr_nxt;
  logic                 oflag_r, oflag_nxt;

  assign prod_ab = lag_value_lower * lag_value_upper;
  assign prod_aa = lag_value_lower * lag_value_lower;
  assign prod_bb = lag_value_upper * lag_value_upper;

  always_comb begin
    cnt_nxt = cnt_r;
    sa_nxt  = sa_r;
    sb_nxt  = sb_r;
    sab_nxt = sab_r;
    saa_nxt = saa_r;
    sbb_nxt = sbb_r;
    ovf_nxt = ovf_r;
    if (cmd.clr) begin
      cnt_nxt = '0;
      sa_nxt  = '0;
      sb_nxt  = '0;
      sab_nxt = '0;
      saa_nxt = '0;
      sbb_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (cmd.acc_en) begin
      if (cnt_r < CW'(MAX_LAGS)) begin
        cnt_nxt = cnt_r + 1'b1;
        sa_nxt  = sa_r + SW'(lag_value_lower);
        sb_nxt  = sb_r + SW'(lag_value_upper);
        sab_nxt = sab_r + XW'(prod_ab);
        saa_nxt = saa_r + QW'(prod_aa[30:0]);
        sbb_nxt = sbb_r + QW'(prod_bb[30:0]);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  assign sa_mag  = sa_r[SW-1] ? SW'(-sa_r) : SW'(sa_r);
  assign sb_mag  = sb_r[SW-1] ? SW'(-sb_r) : SW'(sb_r);
  assign sab_mag = sab_r[XW-1] ? XW'(-sab_r) : XW'(sab_r);
  assign num_mag = num_r[VW-1] ? VW'(-num_r) : VW'(num_r);

  always_comb begin
    op_a    = MW'(cnt_r);
    op_b    = MW'(sab_mag);
    op_sign = 1'b0;
    unique case (cmd.sel)
      acc_pkg::SEL_N_SAB: begin
        op_a    = MW'(cnt_r);
        op_b    = MW'(sab_mag);
        op_sign = sab_r[XW-1];
      end
      acc_pkg::SEL_SA_SB: begin
        op_a    = MW'(sa_mag);
        op_b    = MW'(sb_mag);
        op_sign = sa_r[SW-1] ^ sb_r[SW-1];
      end
      acc_pkg::SEL_N_SAA: begin
        op_a = MW'(cnt_r);
        op_b = MW'(saa_r);
      end
      acc_pkg::SEL_SA_SA: begin
        op_a = MW'(sa_mag);
        op_b = MW'(sa_mag);
      end
      acc_pkg::SEL_N_SBB: begin
        op_a = MW'(cnt_r);
        op_b = MW'(sbb_r);
      end
      acc_pkg::SEL_SB_SB: begin
        op_a = MW'(sb_mag);
        op_b = MW'(sb_mag);
      end
      acc_pkg::SEL_VA_VB: begin
        op_a = va_r[MW-1:0];
        op_b = vb_r[MW-1:0];
      end
      acc_pkg::SEL_NUM_NUM: begin
        op_a = num_mag[MW-1:0];
        op_b = num_mag[MW-1:0];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // one multiplier bit per step, multiplier bits shift out of the bottom as low product bits shift in
  assign madd = mp_r[PW-1:MW] + (mp_r[0] ? {1'b0, ma_r} : {(MW+1){1'b0}});
  assign pm   = VW'(mp_r[MW-1:0]);
  assign spv  = msign_r ? -pm : pm;

  always_comb begin
    ma_nxt    = ma_r;
    mp_nxt    = mp_r;
    msign_nxt = msign_r;
    t0_nxt    = t0_r;
    num_nxt   = num_r;
    va_nxt    = va_r;
    vb_nxt    = vb_r;
    den_nxt   = den_r;
    rhs_nxt   = rhs_r;
    if (cmd.mul_load) begin
      ma_nxt    = op_a;
      mp_nxt    = PW'(op_b);
      msign_nxt = op_sign;
    end else if (cmd.mul_step) begin
      mp_nxt = {1'b0, madd, mp_r[MW-1:1]};
    end
    if (cmd.mul_store) begin
      case (cmd.sel)
        acc_pkg::SEL_SA_SB:   num_nxt = t0_r - spv;
        acc_pkg::SEL_SA_SA:   va_nxt  = t0_r - spv;
        acc_pkg::SEL_SB_SB:   vb_nxt  = t0_r - spv;
        acc_pkg::SEL_VA_VB:   den_nxt = mp_r[2*MW-1:0];
        acc_pkg::SEL_NUM_NUM: rhs_nxt = mp_r[2*MW-1:0];
        default:              t0_nxt  = spv;
      endcase
    end
  end

  // greedy bit search for the largest q with q^2 * den <= num^2 << 28
  assign rhs_sh = TW'({rhs_r, {acc_pkg::FRAC_SHIFT{1'b0}}});
  assign fit    = (trial_r <= rhs_sh);
  assign esum   = {1'b0, e_r} + {d_r, 1'b0};

  always_comb begin
    d_nxt     = d_r;
    e_nxt     = e_r;
    q2d_nxt   = q2d_r;
    trial_nxt = trial_r;
    q_nxt     = q_r;
    if (cmd.sq_init) begin
      d_nxt   = TW'({den_r, {acc_pkg::FRAC_SHIFT{1'b0}}});
      e_nxt   = '0;
      q2d_nxt = '0;
      q_nxt   = '0;
    end else if (cmd.sq_trial) begin
      trial_nxt = q2d_r + e_r + d_r;
    end else if (cmd.sq_update) begin
      d_nxt = d_r >> 2;
      q_nxt = {q_r[QB-2:0], fit};
      if (fit) begin
        q2d_nxt = trial_r;
        e_nxt   = esum[TW:1];
      end else begin
        e_nxt = e_r >> 1;
      end
    end
  end

  assign q_clamp = (q_r > acc_pkg::ONE_Q14) ? acc_pkg::ONE_Q14 : q_r;
  assign mag16   = 16'(q_clamp);

  always_comb begin
    corr_nxt  = corr_r;
    oflag_nxt = oflag_r;
    if (cmd.out_load) begin
      oflag_nxt = ovf_r;
      if (va_r <= 0 || vb_r <= 0) begin
        corr_nxt = '0;
      end else begin
        corr_nxt = num_r[VW-1] ? -$signed(mag16) : $signed(mag16);
      end
    end
  end

  assign correlation   = corr_r;
  assign overflow_flag = oflag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sa_r  <= '0;
      sb_r  <= '0;
      sab_r <= '0;
      saa_r <= '0;
      sbb_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      sa_r  <= sa_nxt;
      sb_r  <= sb_nxt;
      sab_r <= sab_nxt;
      saa_r <= saa_nxt;
      sbb_r <= sbb_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ma_r    <= ma_nxt;
    mp_r    <= mp_nxt;
    msign_r <= msign_nxt;
    t0_r    <= t0_nxt;
    num_r   <= num_nxt;
    va_r    <= va_nxt;
    vb_r    <= vb_nxt;
    den_r   <= den_nxt;
    rhs_r   <= rhs_nxt;
    d_r     <= d_nxt;
    e_r     <= e_nxt;
    q2d_r   <= q2d_nxt;
    trial_r <= trial_nxt;
    q_r     <= q_nxt;
    corr_r  <= corr_nxt;
    oflag_r <= oflag_nxt;
  end

endmodule

/* rtl/core/adjacent_channel_correlation_core.sv */
// accumulation: one lag word per cycle while no evaluation is running
// evaluation after the last lag: eight products on one shared shift-add multiplier
//   (one multiplier bit per cycle), MW = 2*clog2(MAX_LAGS+1)+30 bits wide,
//   then a 15-step root search into the output register
// the next sequence's lags are taken while the result waits on the output
// synchronous active-low reset clears the lag count, the sums and the handshake state
module adjacent_channel_correlation_core #(
  parameter int MAX_LAGS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  acc_in_if.sink    in_ch,
  acc_out_if.source out_ch
);

  acc_pkg::acc_cmd_t cmd;

  acc_ctrl #(
    .MAX_LAGS (MAX_LAGS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_lag),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  acc_dp #(
    .MAX_LAGS (MAX_LAGS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .lag_value_lower (in_ch.lag_value_lower),
    .lag_value_upper (in_ch.lag_value_upper),
    .correlation     (out_ch.correlation),
    .overflow_flag   (out_ch.overflow_flag)
  );

endmodule

/* rtl/core/acc_checker.sv */
module acc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_last,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_corr,
  input logic               out_ovf
);

  // result words stay within plus or minus one
  a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_corr <= 16'sd16384 && out_corr >= -16'sd16384))
    else $error("correlation out of range");

  // a last lag starts the evaluation, so input is held off next cycle
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input taken during evaluation");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result word dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_corr) && $stable(out_ovf)))
    else $error("stalled result word changed");

endmodule

bind adjacent_channel_correlation_core acc_checker u_acc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_lag),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_corr  (out_ch.correlation),
  .out_ovf   (out_ch.overflow_flag)
);

/* verif/adjacent_channel_correlation_checker.sv */
`timescale 1ns / 1ps

module adjacent_channel_correlation_checker #(
  parameter int MAX_LAGS = 256
) (
  input  logic clk,
  input  logic rst_n,
  acc_in_if    in_ch,
  acc_out_if   out_ch,
  output int   fail_count,
  output int   pending_results
);

  typedef struct {
    logic signed [15:0] correlation;
    logic               overflow_flag;
  } corr_result_t;

  corr_result_t expected_q[$];

  int          lag_cnt;
  longint      sum_a, sum_b, sum_ab, sum_aa, sum_bb;
  bit          lags_dropped;

  // largest q in 0..16384 with q^2 * va * vb <= 2^28 * num^2, signed like num
  function automatic int pearson_q14(longint n, longint sa, longint sb, longint sab,
                                     longint saa, longint sbb);
    longint       num, va, vb;
    logic [191:0] den, rhs, trial, mag;
    int           lo, hi, mid;
    num = n * sab - sa * sb;
    va  = n * saa - sa * sa;
    vb  = n * sbb - sb * sb;
    if (va <= 0 || vb <= 0) return 0;
    mag = (num < 0) ? 192'(-num) : 192'(num);
    den = 192'(va) * 192'(vb);
    rhs = (mag * mag) << 28;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      trial = den * 192'(mid * mid);
      if (trial <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (num < 0) ? -lo : lo;
  endfunction

  always @(posedge clk) begin
    longint       a, b;
    int           r;
    corr_result_t e;
    if (!rst_n) begin
      lag_cnt = 0;
      sum_a = 0; sum_b = 0; sum_ab = 0; sum_aa = 0; sum_bb = 0;
      lags_dropped = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        a = in_ch.lag_value_lower;
        b = in_ch.lag_value_upper;
        if (lag_cnt < MAX_LAGS) begin
          sum_a += a; sum_b += b; sum_ab += a * b; sum_aa += a * a; sum_bb += b * b;
          lag_cnt++;
        end else begin
          lags_dropped = 1;
        end
        if (in_ch.last_lag) begin
          r = pearson_q14(lag_cnt, sum_a, sum_b, sum_ab, sum_aa, sum_bb);
          if (r > 16384) r = 16384;
          if (r < -16384) r = -16384;
          e.correlation = 16'(r);
          e.overflow_flag = lags_dropped;
          expected_q.push_back(e);
          lag_cnt = 0;
          sum_a = 0; sum_b = 0; sum_ab = 0; sum_aa = 0; sum_bb = 0;
          lags_dropped = 0;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: correlation %0d overflow %0b",
                     out_ch.correlation, out_ch.overflow_flag);
        end else begin
          e = expected_q.pop_front();
          if (e.correlation !== out_ch.correlation ||
              e.overflow_flag !== out_ch.overflow_flag) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected correlation %0d overflow %0b, got %0d %0b",
                       e.correlation, e.overflow_flag, out_ch.correlation,
                       out_ch.overflow_flag);
          end
        end
      end
    end
    pending_results <= expected_q.size();
  end

  initial begin
    fail_count = 0;
    pending_results = 0;
  end

endmodule

/* verif/adjacent_channel_correlation_core_tb.sv */
`timescale 1ns / 1ps

module adjacent_channel_correlation_core_tb;

  localparam int LAG_LIMIT  = 256;
  localparam int ITEM_GOAL  = 1650;
  localparam int CALM_AFTER = 1400;
  localparam int STALL_MAX  = 5000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_results;
  int   words_sent;
  int   idle_cycles;
  bit   calm;

  acc_in_if  in_ch ();
  acc_out_if out_ch ();

  adjacent_channel_correlation_core #(.MAX_LAGS(LAG_LIMIT)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  adjacent_channel_correlation_checker #(.MAX_LAGS(LAG_LIMIT)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // receiver stalls in bursts, none once calm
  always @(posedge clk) begin
    int hold;
    if (!rst_n) begin
      hold = 0;
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (hold > 0) begin
      hold--;
    end else begin
      hold = $urandom_range(1, 10);
      out_ch.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_MAX) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_lag(logic signed [15:0] a, logic signed [15:0] b, logic last);
    in_ch.valid           <= 1'b1;
    in_ch.lag_value_lower <= a;
    in_ch.lag_value_upper <= b;
    in_ch.last_lag        <= last;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (!calm && words_sent >= CALM_AFTER) calm = 1;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'sh0001;
    endcase
  endfunction

  // shape: 0 free, 1 equal, 2 mirrored, 3 extremes, 4 constant, 5 noisy copy
  task automatic send_sequence(int len, int shape);
    logic signed [15:0] a, b, c;
    c = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      case (shape)
        1: b = a;
        2: b = (a == 16'sh8000) ? 16'sh7fff : -a;
        3: begin a = pick_extreme(); b = pick_extreme(); end
        4: begin a = c; b = c; end
        5: b = a + 16'($signed($urandom_range(0, 2000)) - 1000);
        default: ;
      endcase
      send_lag(a, b, i == len - 1);
    end
  endtask

  initial begin
    int len;
    in_ch.valid           <= 1'b0;
    in_ch.lag_value_lower <= '0;
    in_ch.lag_value_upper <= '0;
    in_ch.last_lag        <= 1'b0;
    rst_n                 <= 1'b0;
    words_sent = 0;
    idle_cycles = 0;
    calm = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single lag, constant, perfect match, perfect inverse, extremes
    send_lag(16'sh7fff, 16'sh8000, 1'b1);
    send_lag(16'sh1234, 16'sh1234, 1'b0);
    send_lag(16'sh1234, 16'sh1234, 1'b1);
    send_lag(16'sh8000, 16'sh8000, 1'b0);
    send_lag(16'sh7fff, 16'sh7fff, 1'b0);
    send_lag(16'sh0000, 16'sh0000, 1'b1);
    send_lag(16'sh8000, 16'sh7fff, 1'b0);
    send_lag(16'sh7fff, 16'sh8000, 1'b0);
    send_lag(16'sh0100, 16'shff00, 1'b1);
    send_lag(16'sh8000, 16'sh0005, 1'b0);
    send_lag(16'sh7fff, 16'sh0005, 1'b1);
    send_lag(16'sh4000, 16'sh2000, 1'b0);
    send_lag(16'shc000, 16'sh6000, 1'b0);
    send_lag(16'sh0001, 16'shffff, 1'b0);
    send_lag(16'shffff, 16'sh0001, 1'b1);

    // let everything drain before new traffic
    // wait so the pending count includes the word just taken
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);

    // a full-length sequence of extremes and an overlong free sequence
    send_sequence(LAG_LIMIT, 3);
    send_sequence(LAG_LIMIT + 1 + $urandom_range(0, 20), 0);

    while (words_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 39))
        0:       len = LAG_LIMIT + $urandom_range(1, 8);
        1:       len = LAG_LIMIT;
        2, 3:    len = 1;
        default: len = $urandom_range(2, 14);
      endcase
      send_sequence(len, $urandom_range(0, 5));
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    while (pending_results != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/acc_pkg.sv
rtl/core/acc_if.sv
rtl/core/acc_ctrl.sv
rtl/core/acc_dp.sv
rtl/core/adjacent_channel_correlation_core.sv
rtl/core/acc_checker.sv
verif/adjacent_channel_correlation_checker.sv
verif/adjacent_channel_correlation_core_tb.sv
